// ===== hdl/aits_pkg.sv =====
// Shared types and constants for the append-only index with time search.
// Used by aits_mem, aits_ctrl and the top level append_index_with_time_search.
// No dependencies.
package aits_pkg;

	localparam int unsigned TABLE_DEPTH_DEF = 1024;
	localparam int unsigned POS_W           = 10;
	localparam int unsigned COUNT_W         = 11;
	localparam int unsigned IN_DATA_W       = 176;
	localparam int unsigned OUT_DATA_W      = 240;

	typedef enum logic [1:0] {
		OP_APPEND      = 2'd0,
		OP_FIND_OFFSET = 2'd1,
		OP_FIND_TIME   = 2'd2,
		OP_READ_AT     = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_FULL      = 2'd1,
		STAT_NOT_FOUND = 2'd2,
		STAT_RANGE     = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN,
		S_BS_ISSUE,
		S_BS_CHECK,
		S_READ_WAIT,
		S_DONE
	} state_t;

	// one stored table entry
	typedef struct packed {
		logic [63:0] time_key;
		logic [31:0] entry_len;
		logic [63:0] msg_offset;
	} entry_t;

	typedef struct packed {
		op_t               opcode;
		logic [63:0]       msg_offset;
		logic [31:0]       entry_len;
		logic [63:0]       time_key;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		stat_t              status;
		logic [63:0]        found_offset;
		logic [31:0]        found_len;
		logic [63:0]        found_time;
		logic [COUNT_W-1:0] count_now;
		logic [63:0]        newest_offset;
	} res_t;

endpackage

// ===== hdl/aits_mem.sv =====
// Entry memory: one write port, one read port, read data registered.
// Depends on aits_pkg (entry_t).
module aits_mem #(
	parameter int unsigned DEPTH = aits_pkg::TABLE_DEPTH_DEF,
	localparam int unsigned AW   = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            we,
	input  logic [AW-1:0]   waddr,
	input  aits_pkg::entry_t wdata,
	input  logic            re,
	input  logic [AW-1:0]   raddr,
	output aits_pkg::entry_t rdata
);

	aits_pkg::entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== hdl/aits_ctrl.sv =====
// Request sequencer: append, linear scan by offset, binary search by time, read at index.
// Drives the entry memory ports of aits_mem; depends on aits_pkg.
module aits_ctrl #(
	parameter int unsigned TABLE_DEPTH = aits_pkg::TABLE_DEPTH_DEF,
	localparam int unsigned AW = $clog2(TABLE_DEPTH),
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_ready,
	input  aits_pkg::req_t   req,
	output logic             res_valid,
	input  logic             res_ready,
	output aits_pkg::res_t   res,
	output logic             mem_we,
	output logic [AW-1:0]    mem_waddr,
	output aits_pkg::entry_t mem_wdata,
	output logic             mem_re,
	output logic [AW-1:0]    mem_raddr,
	input  aits_pkg::entry_t mem_rdata
);

	localparam int unsigned PW = (CW > aits_pkg::POS_W) ? CW : aits_pkg::POS_W;

	aits_pkg::state_t state_q, state_d;

	aits_pkg::req_t   req_q;
	logic [CW-1:0]    cnt_q;
	logic [63:0]      last_q;
	logic [CW-1:0]    scan_idx_q;
	logic             pend_q;
	logic [CW-1:0]    lo_q;
	logic [CW-1:0]    hi_q;
	logic [CW-1:0]    mid_q;
	logic             have_q;
	aits_pkg::entry_t ent_q;
	aits_pkg::stat_t  status_q;

	logic [CW:0]      mid_sum;
	logic [CW-1:0]    mid;
	logic [PW-1:0]    pos_ext;
	logic             match;
	logic             scan_issue;
	logic             time_ge;

	logic             fin;
	aits_pkg::stat_t  fin_status;
	logic             fin_have;
	aits_pkg::entry_t fin_ent;

	assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = mid_sum[CW:1];
	assign pos_ext    = PW'(req_q.position);
	assign match      = pend_q && (mem_rdata.msg_offset == req_q.msg_offset);
	assign scan_issue = !match && (scan_idx_q < cnt_q);
	assign time_ge    = mem_rdata.time_key >= req_q.time_key;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aits_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		req_ready  = 1'b0;
		res_valid  = 1'b0;
		mem_we     = 1'b0;
		mem_waddr  = cnt_q[AW-1:0];
		mem_wdata  = '{time_key: req_q.time_key, entry_len: req_q.entry_len,
			msg_offset: req_q.msg_offset};
		mem_re     = 1'b0;
		mem_raddr  = scan_idx_q[AW-1:0];
		fin        = 1'b0;
		fin_status = aits_pkg::STAT_OK;
		fin_have   = 1'b0;
		fin_ent    = mem_rdata;
		case (state_q)
			aits_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = aits_pkg::S_DISPATCH;
				end
			end
			aits_pkg::S_DISPATCH: begin
				case (req_q.opcode)
					aits_pkg::OP_APPEND: begin
						fin = 1'b1;
						if (cnt_q >= CW'(TABLE_DEPTH)) begin
							fin_status = aits_pkg::STAT_FULL;
						end else begin
							mem_we = 1'b1;
						end
					end
					aits_pkg::OP_FIND_OFFSET: begin
						state_d = aits_pkg::S_SCAN;
					end
					aits_pkg::OP_FIND_TIME: begin
						if (cnt_q == '0) begin
							fin        = 1'b1;
							fin_status = aits_pkg::STAT_NOT_FOUND;
						end else begin
							state_d = aits_pkg::S_BS_ISSUE;
						end
					end
					aits_pkg::OP_READ_AT: begin
						if (pos_ext >= PW'(cnt_q)) begin
							fin        = 1'b1;
							fin_status = aits_pkg::STAT_RANGE;
						end else begin
							mem_re    = 1'b1;
							mem_raddr = pos_ext[AW-1:0];
							state_d   = aits_pkg::S_READ_WAIT;
						end
					end
					default: begin
						fin        = 1'b1;
						fin_status = aits_pkg::STAT_NOT_FOUND;
					end
				endcase
			end
			aits_pkg::S_SCAN: begin
				// one read issued per cycle, data checked in the next cycle
				if (match) begin
					fin      = 1'b1;
					fin_have = 1'b1;
				end else if (scan_issue) begin
					mem_re = 1'b1;
				end else begin
					fin        = 1'b1;
					fin_status = aits_pkg::STAT_NOT_FOUND;
				end
			end
			aits_pkg::S_BS_ISSUE: begin
				if (lo_q > hi_q) begin
					fin        = 1'b1;
					fin_have   = have_q;
					fin_ent    = ent_q;
					fin_status = have_q ? aits_pkg::STAT_OK : aits_pkg::STAT_NOT_FOUND;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = mid[AW-1:0];
					state_d   = aits_pkg::S_BS_CHECK;
				end
			end
			aits_pkg::S_BS_CHECK: begin
				if (time_ge && (mid_q == '0)) begin
					fin      = 1'b1;
					fin_have = 1'b1;
				end else begin
					state_d = aits_pkg::S_BS_ISSUE;
				end
			end
			aits_pkg::S_READ_WAIT: begin
				fin      = 1'b1;
				fin_have = 1'b1;
			end
			aits_pkg::S_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = aits_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = aits_pkg::S_IDLE;
			end
		endcase
		if (fin) begin
			state_d = aits_pkg::S_DONE;
		end
	end

	// table state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			last_q <= '0;
		end else if (mem_we) begin
			cnt_q  <= cnt_q + CW'(1);
			last_q <= req_q.msg_offset;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (state_q == aits_pkg::S_SCAN) begin
			pend_q <= scan_issue;
		end else begin
			pend_q <= 1'b0;
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
		if (fin) begin
			status_q <= fin_status;
			have_q   <= fin_have;
			ent_q    <= fin_ent;
		end else begin
			case (state_q)
				aits_pkg::S_DISPATCH: begin
					scan_idx_q <= '0;
					lo_q       <= '0;
					hi_q       <= cnt_q - CW'(1);
					have_q     <= 1'b0;
				end
				aits_pkg::S_SCAN: begin
					if (scan_issue) begin
						scan_idx_q <= scan_idx_q + CW'(1);
					end
				end
				aits_pkg::S_BS_ISSUE: begin
					mid_q <= mid;
				end
				aits_pkg::S_BS_CHECK: begin
					if (time_ge) begin
						ent_q  <= mem_rdata;
						have_q <= 1'b1;
						hi_q   <= mid_q - CW'(1);
					end else begin
						lo_q <= mid_q + CW'(1);
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		res.status        = status_q;
		res.found_offset  = have_q ? ent_q.msg_offset : 64'd0;
		res.found_len     = have_q ? ent_q.entry_len : 32'd0;
		res.found_time    = have_q ? ent_q.time_key : 64'd0;
		res.count_now     = aits_pkg::COUNT_W'(cnt_q);
		res.newest_offset = last_q;
	end

endmodule

// ===== hdl/append_index_with_time_search.sv =====
// Append-only index table with lookup by offset, by time and by position.
// Append, full, out of range and find by time on an empty table end at dispatch;
// read at index waits for one memory read; find by time binary-searches with at
// most log2(count)+1 probes; find by offset scans from entry 0 to a match or end.
// One request at a time: the next waits for the result to enter the output register.
// Reset clears the entry count and newest offset; the entry memory is not cleared.
module append_index_with_time_search #(
	parameter int unsigned TABLE_DEPTH = aits_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// msg_offset[63:0], entry_len[95:64], time_key[159:96], position[169:160], zero pad
	input  logic [aits_pkg::IN_DATA_W-1:0]  s_tdata,
	// opcode[1:0]
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// found_offset[63:0], found_len[95:64], found_time[159:96], count_now[170:160],
	// newest_offset[234:171], zero pad
	output logic [aits_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[1:0]
	output logic [1:0]                      m_tuser
);

	localparam int unsigned AW = $clog2(TABLE_DEPTH);

	aits_pkg::req_t   req;
	aits_pkg::res_t   res;
	logic             res_valid;
	logic             res_ready;
	logic             mem_we;
	logic [AW-1:0]    mem_waddr;
	aits_pkg::entry_t mem_wdata;
	logic             mem_re;
	logic [AW-1:0]    mem_raddr;
	aits_pkg::entry_t mem_rdata;

	logic             out_valid_q;
	aits_pkg::res_t   out_q;

	always_comb begin
		req.opcode     = aits_pkg::op_t'(s_tuser);
		req.msg_offset = s_tdata[63:0];
		req.entry_len  = s_tdata[95:64];
		req.time_key   = s_tdata[159:96];
		req.position   = s_tdata[169:160];
	end

	aits_ctrl #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_tvalid),
		.req_ready (s_tready),
		.req       (req),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	aits_mem #(
		.DEPTH(TABLE_DEPTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// output register decouples the sequencer from the downstream stall
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.status;
	assign m_tdata  = {5'd0, out_q.newest_offset, out_q.count_now, out_q.found_time,
		out_q.found_len, out_q.found_offset};

`ifndef SYNTHESIS
	// sequencer never takes a request while a result is still pending inside it
	a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !res_valid)
		else $error("request accepted while result pending");

	// only one request in flight
	a_single_request: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request accepted back to back");

	// failed operations carry no entry
	a_no_entry_on_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_q.status != aits_pkg::STAT_OK)) |->
		(out_q.found_offset == 64'd0 && out_q.found_len == 32'd0 &&
		out_q.found_time == 64'd0))
		else $error("entry fields set on failed operation");
`endif

endmodule

// ===== tb/aits_checker.sv =====
`timescale 1ns / 1ps
// Checker for append_index_with_time_search: watches both stream channels,
// keeps its own copy of the index table and compares every reply field by field.
// Depends on aits_pkg.
module aits_checker #(
	parameter int unsigned DEPTH = aits_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [aits_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic [1:0]                      s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [aits_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic [1:0]                      m_tuser,
	output int                              errors,
	output int                              outstanding
);

	logic [63:0] shadow_off  [DEPTH];
	logic [31:0] shadow_len  [DEPTH];
	logic [63:0] shadow_time [DEPTH];
	int unsigned entries;
	logic [63:0] newest;

	aits_pkg::res_t reply_q [$];
	aits_pkg::res_t predicted;
	aits_pkg::res_t seen;
	int             replies_seen;

	initial begin
		errors = 0;
		outstanding = 0;
		entries = 0;
		newest = '0;
		replies_seen = 0;
	end

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch on reply %0d, %s: got %h, want %h", replies_seen, field, got, want);
		errors++;
	endtask

	// applies one request to the table copy and works out its reply
	task automatic predict_reply(input aits_pkg::op_t op, input logic [63:0] off,
			input logic [31:0] len, input logic [63:0] key, input logic [9:0] pos,
			output aits_pkg::res_t r);
		int  lo;
		int  hi;
		int  mid;
		int  i;
		int  slot;
		bit  hit;
		r = '0;
		r.status = aits_pkg::STAT_OK;
		hit = 1'b0;
		slot = 0;
		case (op)
		aits_pkg::OP_APPEND: begin
			if (entries >= DEPTH) begin
				r.status = aits_pkg::STAT_FULL;
			end else begin
				shadow_off[entries] = off;
				shadow_len[entries] = len;
				shadow_time[entries] = key;
				entries++;
				newest = off;
			end
		end
		aits_pkg::OP_FIND_OFFSET: begin
			for (i = 0; i < int'(entries) && !hit; i++)
				if (shadow_off[i] == off) begin
					hit = 1'b1;
					slot = i;
				end
			if (!hit)
				r.status = aits_pkg::STAT_NOT_FOUND;
		end
		aits_pkg::OP_FIND_TIME: begin
			// lower-bound search; hi going negative also covers the stop at index 0
			lo = 0;
			hi = int'(entries) - 1;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (shadow_time[mid] >= key) begin
					hit = 1'b1;
					slot = mid;
					hi = mid - 1;
				end else begin
					lo = mid + 1;
				end
			end
			if (!hit)
				r.status = aits_pkg::STAT_NOT_FOUND;
		end
		default: begin
			if (pos >= entries) begin
				r.status = aits_pkg::STAT_RANGE;
			end else begin
				hit = 1'b1;
				slot = pos;
			end
		end
		endcase
		if (hit) begin
			r.found_offset = shadow_off[slot];
			r.found_len = shadow_len[slot];
			r.found_time = shadow_time[slot];
		end
		r.count_now = entries[aits_pkg::COUNT_W-1:0];
		r.newest_offset = newest;
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			seen.status = aits_pkg::stat_t'(m_tuser);
			seen.found_offset = m_tdata[63:0];
			seen.found_len = m_tdata[95:64];
			seen.found_time = m_tdata[159:96];
			seen.count_now = m_tdata[170:160];
			seen.newest_offset = m_tdata[234:171];
			if (reply_q.size() == 0) begin
				report_mismatch("reply with no request pending", '0, '0);
			end else begin
				predicted = reply_q.pop_front();
				if (seen.status != predicted.status)
					report_mismatch("status", 64'(seen.status), 64'(predicted.status));
				if (seen.found_offset != predicted.found_offset)
					report_mismatch("found_offset", seen.found_offset, predicted.found_offset);
				if (seen.found_len != predicted.found_len)
					report_mismatch("found_len", 64'(seen.found_len),
						64'(predicted.found_len));
				if (seen.found_time != predicted.found_time)
					report_mismatch("found_time", seen.found_time, predicted.found_time);
				if (seen.count_now != predicted.count_now)
					report_mismatch("count_now", 64'(seen.count_now),
						64'(predicted.count_now));
				if (seen.newest_offset != predicted.newest_offset)
					report_mismatch("newest_offset", seen.newest_offset,
						predicted.newest_offset);
			end
			replies_seen++;
		end
		if (arst_n && s_tvalid && s_tready) begin
			predict_reply(aits_pkg::op_t'(s_tuser), s_tdata[63:0], s_tdata[95:64],
				s_tdata[159:96], s_tdata[169:160], predicted);
			reply_q.push_back(predicted);
		end
		outstanding = reply_q.size();
	end

endmodule

// ===== tb/tb_append_index_with_time_search.sv =====
`timescale 1ns / 1ps
// Top of the testbench for append_index_with_time_search: clock, reset, request
// stimulus, reply back-pressure and the verdict. Needs aits_pkg, the block and aits_checker.
module tb_append_index_with_time_search;

	localparam int unsigned DEPTH = aits_pkg::TABLE_DEPTH_DEF;
	localparam int LIMIT = 10_000_000;
	localparam int RANDOM_REQUESTS = 560;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [aits_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [1:0]                      s_tuser = '0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [aits_pkg::OUT_DATA_W-1:0] m_tdata;
	logic [1:0]                      m_tuser;

	int errors;
	int outstanding;
	int accepted_cnt = 0;
	int cycle_cnt = 0;
	bit held_off = 1'b0;

	// what has been stored so far, used to aim lookups at real entries
	logic [63:0] sent_offs [$];
	logic [63:0] sent_times [$];
	logic [63:0] next_off;
	logic [63:0] next_time;

	append_index_with_time_search #(.TABLE_DEPTH(DEPTH)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	aits_checker #(.DEPTH(DEPTH)) chk (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.errors(errors), .outstanding(outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (s_tvalid && s_tready)
			accepted_cnt <= accepted_cnt + 1;
	end

	// idle percentages follow the request count: sender 32 / receiver 75,
	// then swapped, then no idling
	function automatic int tx_idle_pct();
		if (accepted_cnt < 220)
			return 32;
		if (accepted_cnt < 440)
			return 75;
		return 0;
	endfunction

	function automatic int rx_idle_pct();
		if (accepted_cnt < 220)
			return 75;
		if (accepted_cnt < 440)
			return 32;
		return 0;
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic send(input aits_pkg::op_t op, input logic [63:0] off,
			input logic [31:0] len, input logic [63:0] key, input logic [9:0] pos);
		while ($urandom_range(99) < tx_idle_pct()) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {6'd0, pos, key, len, off};
		do
			@(posedge clk);
		while (!s_tready);
		if (op == aits_pkg::OP_APPEND && sent_offs.size() < DEPTH) begin
			sent_offs.push_back(off);
			sent_times.push_back(key);
		end
	endtask

	// mostly ascending offsets and timestamps; a few duplicates, step-backs and
	// random values keep the unordered and first-match paths busy
	task automatic random_request();
		int            r;
		int            k;
		int            idx;
		aits_pkg::op_t op;
		logic [63:0]   off;
		logic [63:0]   key;
		logic [31:0]   len;
		logic [9:0]    pos;
		r = $urandom_range(99);
		off = rand64();
		key = rand64();
		len = $urandom;
		pos = 10'($urandom_range(1023));
		if (r < 45) begin
			op = aits_pkg::OP_APPEND;
			k = $urandom_range(99);
			if (k < 85) begin
				next_off = next_off + $urandom_range(1, 3);
				off = next_off;
			end else if (k < 93 && sent_offs.size() > 0) begin
				off = sent_offs[$urandom_range(sent_offs.size() - 1)];
			end
			k = $urandom_range(99);
			if (k < 94) begin
				next_time = next_time + $urandom_range(0, 40);
				key = next_time;
			end else if (k < 97 && sent_times.size() > 0) begin
				key = sent_times[$] - $urandom_range(1, 20);
			end
		end else if (r < 65) begin
			op = aits_pkg::OP_FIND_OFFSET;
			if ($urandom_range(99) < 70 && sent_offs.size() > 0)
				off = sent_offs[$urandom_range(sent_offs.size() - 1)];
		end else if (r < 85) begin
			op = aits_pkg::OP_FIND_TIME;
			k = $urandom_range(99);
			if (k < 60 && sent_times.size() > 0) begin
				idx = $urandom_range(sent_times.size() - 1);
				case ($urandom_range(2))
				0: key = sent_times[idx] - 1;
				1: key = sent_times[idx];
				default: key = sent_times[idx] + 1;
				endcase
			end else if (k < 70) begin
				key = '0;
			end else if (k < 80) begin
				key = '1;
			end
		end else begin
			op = aits_pkg::OP_READ_AT;
			if ($urandom_range(99) < 80 && sent_offs.size() > 0)
				pos = 10'($urandom_range(sent_offs.size() - 1));
		end
		send(op, off, len, key, pos);
	endtask

	// reply side: random stalls, plus one long hold-off that backs up the input
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held_off && accepted_cnt >= 300) begin
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= rx_idle_pct());
			end
		end
	end

	initial begin
		wait (cycle_cnt >= LIMIT);
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table
		send(aits_pkg::OP_FIND_OFFSET, 64'd0, 32'd0, 64'd0, 10'd0);
		send(aits_pkg::OP_FIND_TIME, 64'd0, 32'd0, 64'd0, 10'd0);
		send(aits_pkg::OP_READ_AT, 64'd0, 32'd0, 64'd0, 10'd0);
		send(aits_pkg::OP_READ_AT, '1, '1, '1, 10'h3FF);
		// field extremes, equal timestamps and a repeated offset
		send(aits_pkg::OP_APPEND, 64'd0, 32'd0, 64'd0, 10'd0);
		send(aits_pkg::OP_APPEND, 64'd1, '1, 64'd10, 10'd0);
		send(aits_pkg::OP_APPEND, '1, 32'd5, 64'd10, 10'd0);
		send(aits_pkg::OP_APPEND, 64'd1, 32'd7, 64'd200, 10'd0);
		send(aits_pkg::OP_FIND_OFFSET, 64'd1, 32'd0, 64'd0, 10'd0);
		send(aits_pkg::OP_FIND_OFFSET, '1, 32'd0, 64'd0, 10'd0);
		send(aits_pkg::OP_FIND_OFFSET, 64'h5555_5555_5555_5555, 32'd0, 64'd0, 10'd0);
		send(aits_pkg::OP_FIND_TIME, 64'd0, 32'd0, 64'd0, 10'd0);
		send(aits_pkg::OP_FIND_TIME, 64'd0, 32'd0, 64'd10, 10'd0);
		send(aits_pkg::OP_FIND_TIME, 64'd0, 32'd0, 64'd11, 10'd0);
		send(aits_pkg::OP_FIND_TIME, 64'd0, 32'd0, 64'd201, 10'd0);
		send(aits_pkg::OP_FIND_TIME, 64'd0, 32'd0, '1, 10'd0);
		send(aits_pkg::OP_READ_AT, 64'd0, 32'd0, 64'd0, 10'd0);
		send(aits_pkg::OP_READ_AT, 64'd0, 32'd0, 64'd0, 10'd3);
		send(aits_pkg::OP_READ_AT, 64'd0, 32'd0, 64'd0, 10'd4);

		next_off = 64'd2;
		next_time = 64'd300;
		repeat (RANDOM_REQUESTS) random_request();
		s_tvalid <= 1'b0;

		while (outstanding != 0)
			@(posedge clk);
		repeat (1100) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/aits_pkg.sv
hdl/aits_mem.sv
hdl/aits_ctrl.sv
hdl/append_index_with_time_search.sv
tb/aits_checker.sv
tb/tb_append_index_with_time_search.sv
